### hdl/matrix_multiply_mod_prime_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular matrix multiplier
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_MOD_PRIME_MACROS_SVH
`define MATRIX_MULTIPLY_MOD_PRIME_MACROS_SVH

`ifndef ASSERT_OFF
`define MMMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define MMMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMMP_ASSERT(label, prop, msg)
`define MMMP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hdl/mmmp_pkg.sv
// ----------------------------------------------------------------------------
// mmmp_pkg
// Shared types and constants of the modular matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mmmp_pkg;

    localparam int DEF_MAX_DIM = 8;

    localparam int VALUE_W   = 30;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [VALUE_W-1:0] MODULUS    = 30'd1000000007;
    localparam logic [31:0]        MODULUS_X2 = 32'd2000000014;
    localparam logic [31:0]        MODULUS_X3 = 32'd3000000021;

    // Barrett constant floor(2^60 / modulus); it needs 31 bits.
    localparam logic [63:0] BARRETT_MU_W = (64'd1 << 60) / {34'd0, MODULUS};
    localparam logic [30:0] BARRETT_MU   = BARRETT_MU_W[30:0];

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_OF_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_OF_B  = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_QUOT,
        PH_REM,
        PH_RED
    } t_mul_phase;

endpackage

`default_nettype wire

### hdl/mmmp_mod_mul.sv
// ----------------------------------------------------------------------------
// mmmp_mod_mul
// Multiplier modulo the prime: one 31x31 multiplier used three times per
// request (product, Barrett quotient, quotient times modulus), then a final
// correction. The result appears with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_multiply_mod_prime_macros.svh"

module mmmp_mod_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [mmmp_pkg::VALUE_W-1:0] i_x,
    input  wire logic [mmmp_pkg::VALUE_W-1:0] i_y,
    output logic                              o_done,
    output logic [mmmp_pkg::VALUE_W-1:0]      o_result
);
    import mmmp_pkg::*;

    t_mul_phase r_phase, n_phase;
    logic       r_done, n_done;

    logic [59:0]        r_prod;
    logic [29:0]        r_quot;
    logic [31:0]        r_rem;
    logic [VALUE_W-1:0] r_result;

    logic [30:0]        op_a, op_b;
    logic [61:0]        mul;
    logic [31:0]        rem_fixed;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_phase)
            PH_QUOT: begin
                op_a = r_prod[59:29];
                op_b = BARRETT_MU;
            end
            PH_REM: begin
                op_a = {1'b0, r_quot};
                op_b = {1'b0, MODULUS};
            end
            default: begin
                op_a = {1'b0, i_x};
                op_b = {1'b0, i_y};
            end
        endcase
    end

    assign mul = {31'd0, op_a} * {31'd0, op_b};

    // The Barrett quotient is short by at most two, so the remainder is below
    // three times the modulus.
    always_comb begin
        if (r_rem >= MODULUS_X2) begin
            rem_fixed = r_rem - MODULUS_X2;
        end else if (r_rem >= {2'b00, MODULUS}) begin
            rem_fixed = r_rem - {2'b00, MODULUS};
        end else begin
            rem_fixed = r_rem;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_phase = PH_QUOT;
                end
            end
            PH_QUOT: n_phase = PH_REM;
            PH_REM:  n_phase = PH_RED;
            PH_RED: begin
                n_phase = PH_IDLE;
                n_done  = 1'b1;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_start) begin
            r_prod <= mul[59:0];
        end
        if (r_phase == PH_QUOT) begin
            r_quot <= mul[60:31];
        end
        if (r_phase == PH_REM) begin
            r_rem <= r_prod[31:0] - mul[31:0];
        end
        if (r_phase == PH_RED) begin
            r_result <= rem_fixed[VALUE_W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `MMMP_ASSERT(a_start_when_idle, !i_start || r_phase == PH_IDLE, "start while busy")
    `MMMP_ASSERT(a_rem_bound, r_phase != PH_RED || r_rem < MODULUS_X3, "remainder too large")
    `MMMP_ASSERT(a_result_reduced, !o_done || o_result < MODULUS, "result not reduced")

endmodule

`default_nettype wire

### hdl/matrix_multiply_mod_prime.sv
// ----------------------------------------------------------------------------
// matrix_multiply_mod_prime
// Multiplies A (rows_of_a x inner_size) by B (inner_size x cols_of_b) modulo
// the prime 1000000007 and streams out C in row-major order.
// ----------------------------------------------------------------------------
// Elements enter on the slave stream, one per cycle while o_s_tready is high;
// tuser selects A (0) or B (1) and tdata carries the value, which is reduced
// modulo the prime on entry. Elements for a full matrix are dropped.
// When the request that completes both matrices is taken, o_s_tready falls
// and one modular multiply-accumulate unit computes C. Each term takes a
// store read, a start and a pass through the multiplier; after the last term
// of an element of C the sequencer emits the sum.
// Results wait in an output register; the sequencer goes on computing the
// next element and only halts when that register is still full. o_m_tlast
// marks the final element of C. The dimension registers are to be written
// through the plain write port only while the block is idle; the block itself
// does not enforce this. 0 counts as 1 and values above MAX_DIM as MAX_DIM.
// Reset empties both matrices, sets the dimensions to 1 and drops any pending
// result; the element stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_multiply_mod_prime_macros.svh"

module matrix_multiply_mod_prime #(
    parameter int MAX_DIM = mmmp_pkg::DEF_MAX_DIM
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write port.
    input  wire logic                           i_cfg_we,
    input  wire logic [mmmp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mmmp_pkg::CFG_W-1:0]     i_cfg_data,
    // Element input.
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [mmmp_pkg::DATA_W-1:0]    i_s_tdata,   // [29:0] element_value
    input  wire logic                           i_s_tuser,   // [0] func
    // Result output.
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [mmmp_pkg::DATA_W-1:0]         o_m_tdata,   // [29:0] product_value
    output logic                                o_m_tlast    // last_element
);
    import mmmp_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW    = $clog2(DEPTH + 1);

    // Dimension registers.
    logic [CFG_W-1:0] r_rows_of_a, r_inner_size, r_cols_of_b;
    logic [DW-1:0]    n_dim, p_dim, m_dim;

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DW-1:0] res;
        if (v == '0) begin
            res = DW'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            res = DW'(MAX_DIM);
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

    assign n_dim = clamp_dim(r_rows_of_a);
    assign p_dim = clamp_dim(r_inner_size);
    assign m_dim = clamp_dim(r_cols_of_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_of_a  <= CFG_W'(1);
            r_inner_size <= CFG_W'(1);
            r_cols_of_b  <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS_OF_A:  r_rows_of_a  <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COLS_OF_B:  r_cols_of_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Matrix sizes and store addresses.
    logic [2*DW-1:0] size_a_w, size_b_w, base_a_w, base_b_w, addr_a_w, addr_b_w;
    logic [CW-1:0]   size_a, size_b;
    logic [AW-1:0]   rd_addr_a, rd_addr_b;

    assign size_a_w = {{DW{1'b0}}, n_dim} * {{DW{1'b0}}, p_dim};
    assign size_b_w = {{DW{1'b0}}, p_dim} * {{DW{1'b0}}, m_dim};
    assign size_a   = size_a_w[CW-1:0];
    assign size_b   = size_b_w[CW-1:0];

    // Sequencer state and data registers.
    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [DW-1:0]      r_i, n_i, r_j, n_j, r_k, n_k;
    logic [VALUE_W-1:0] r_sum, n_sum;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_data, n_out_data;
    logic               r_out_last, n_out_last;

    assign base_a_w  = {{DW{1'b0}}, r_i} * {{DW{1'b0}}, p_dim};
    assign base_b_w  = {{DW{1'b0}}, r_k} * {{DW{1'b0}}, m_dim};
    assign addr_a_w  = base_a_w + {{DW{1'b0}}, r_k};
    assign addr_b_w  = base_b_w + {{DW{1'b0}}, r_j};
    assign rd_addr_a = addr_a_w[AW-1:0];
    assign rd_addr_b = addr_b_w[AW-1:0];

    // Element stores.
    logic [VALUE_W-1:0] mem_a [2**AW];
    logic [VALUE_W-1:0] mem_b [2**AW];
    logic [VALUE_W-1:0] r_rd_a, r_rd_b;
    logic               wr_a, wr_b;
    logic [VALUE_W-1:0] in_value, entry_value;

    assign in_value    = i_s_tdata[VALUE_W-1:0];
    assign entry_value = (in_value >= MODULUS) ? in_value - MODULUS : in_value;

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[r_cnt_a[AW-1:0]] <= entry_value;
        end
        r_rd_a <= mem_a[rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[r_cnt_b[AW-1:0]] <= entry_value;
        end
        r_rd_b <= mem_b[rd_addr_b];
    end

    // Shared modular multiplier.
    logic               mul_start, mul_done;
    logic [VALUE_W-1:0] mul_result;

    mmmp_mod_mul u_mod_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_x      (r_rd_a),
        .i_y      (r_rd_b),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    logic [VALUE_W:0]   acc_w;
    logic [VALUE_W-1:0] acc_next;

    assign acc_w    = {1'b0, r_sum} + {1'b0, mul_result};
    assign acc_next = (acc_w >= {1'b0, MODULUS}) ? VALUE_W'(acc_w - {1'b0, MODULUS})
                                                 : acc_w[VALUE_W-1:0];

    logic s_accept, out_free, i_last, j_last, k_last;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign i_last   = (r_i == DW'(n_dim - 1'b1));
    assign j_last   = (r_j == DW'(m_dim - 1'b1));
    assign k_last   = (r_k == DW'(p_dim - 1'b1));

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        wr_a        = 1'b0;
        wr_b        = 1'b0;
        mul_start   = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (s_accept) begin
                    if (!i_s_tuser && r_cnt_a < size_a) begin
                        wr_a    = 1'b1;
                        n_cnt_a = r_cnt_a + 1'b1;
                    end
                    if (i_s_tuser && r_cnt_b < size_b) begin
                        wr_b    = 1'b1;
                        n_cnt_b = r_cnt_b + 1'b1;
                    end
                    // Completion is judged against the dimensions in force now.
                    if (n_cnt_a >= size_a && n_cnt_b >= size_b) begin
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_sum   = '0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: n_state = ST_START;
            ST_START: begin
                mul_start = 1'b1;
                n_state   = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    n_sum = acc_next;
                    if (k_last) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_sum;
                    n_out_last  = i_last && j_last;
                    n_sum       = '0;
                    n_k         = '0;
                    n_state     = ST_READ;
                    if (j_last) begin
                        n_j = '0;
                        if (i_last) begin
                            n_i     = '0;
                            n_state = ST_LOAD;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_s_tready = (r_state == ST_LOAD);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(DATA_W - VALUE_W){1'b0}}, r_out_data};
    assign o_m_tlast  = r_out_last;

    `MMMP_ASSERT(a_sum_reduced, r_sum < MODULUS, "accumulator not reduced")
    `MMMP_ASSERT(a_out_reduced, !r_out_valid || r_out_data < MODULUS, "result not reduced")
    `MMMP_ASSERT(a_done_in_wait, !mul_done || r_state == ST_WAIT, "multiplier done out of turn")
    `MMMP_ASSERT_NEXT(a_last_to_load, r_state == ST_EMIT && out_free && i_last && j_last,
        r_state == ST_LOAD && r_out_valid && r_out_last, "final result did not end the run")

endmodule

`default_nettype wire
